@@ hdl/conv3_pkg.sv @@
package conv3_pkg;

    // kernel geometry
    localparam int KERNEL_SIZE = 3;
    localparam int KCENTER     = (KERNEL_SIZE - 1) / 2;

    // field and register widths
    localparam int PIX_W       = 16;
    localparam int COEF_W      = 16;
    localparam int COEF_ROW_W  = 48;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 13;
    localparam int MAX_HEIGHT  = 4096;
    localparam int OUT_ROW_W   = $clog2(MAX_HEIGHT);
    localparam int CFG_INDEX_W = 3;

    // output queue
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
    localparam int OCC_W       = $clog2(OFIFO_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_TOP     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_MID     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_BOT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 3'd4;

    // register reset values
    localparam logic [COEF_ROW_W-1:0] COEF_TOP_RST = 48'h0000_0000_0000;
    localparam logic [COEF_ROW_W-1:0] COEF_MID_RST = 48'h0000_1000_0000;
    localparam logic [COEF_ROW_W-1:0] COEF_BOT_RST = 48'h0000_0000_0000;
    localparam logic [WIDTH_W-1:0]    WIDTH_RST    = 11'd1024;
    localparam logic [HEIGHT_W-1:0]   HEIGHT_RST   = 13'd1024;

    // item kinds
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef logic signed [PIX_W-1:0] pix_t;
    typedef pix_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] win_t;

    typedef struct packed {
        logic action;
        pix_t pixel_value;
    } in_item_t;

    typedef struct packed {
        pix_t out_value;
        logic out_last;
    } out_item_t;

    // one line buffer entry: the two stored rows at a column
    typedef struct packed {
        pix_t newer;
        pix_t older;
    } lb_word_t;

    // per-output control handed to the arithmetic pipeline
    typedef struct packed {
        logic valid;
        logic last;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } mac_ctrl_t;

endpackage

@@ hdl/conv3_lbuf.sv @@
module conv3_lbuf #(
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output conv3_pkg::lb_word_t rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  conv3_pkg::lb_word_t wr_data
);

    conv3_pkg::lb_word_t mem [DEPTH];
    conv3_pkg::lb_word_t ram_q_reg;
    conv3_pkg::lb_word_t fwd_data_reg;
    logic                fwd_hit_reg;

    // single port pair, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            ram_q_reg <= mem[rd_addr];
        end
    end

    // bypass a write to the entry being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : ram_q_reg;

endmodule

@@ hdl/conv3_mac.sv @@
module conv3_mac #(
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  conv3_pkg::win_t                       win,
    input  conv3_pkg::mac_ctrl_t                  ctrl,
    input  logic [conv3_pkg::COEF_ROW_W-1:0]      coef_top,
    input  logic [conv3_pkg::COEF_ROW_W-1:0]      coef_mid,
    input  logic [conv3_pkg::COEF_ROW_W-1:0]      coef_bot,
    output logic                                  res_valid,
    output conv3_pkg::out_item_t                  res
);

    localparam int KS        = conv3_pkg::KERNEL_SIZE;
    localparam int CW        = conv3_pkg::COEF_W;
    localparam int PROD_W    = conv3_pkg::PIX_W + CW;
    localparam int ROW_SUM_W = PROD_W + 2;
    localparam int SUM_W     = PROD_W + 4;
    localparam int RND       = (COEF_FRAC_BITS > 0) ? (1 << (COEF_FRAC_BITS - 1)) : 0;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (conv3_pkg::PIX_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    typedef logic signed [PROD_W-1:0]    prod_t;
    typedef logic signed [ROW_SUM_W-1:0] row_sum_t;

    logic [KS-1:0][conv3_pkg::COEF_ROW_W-1:0] kern_rows;
    prod_t [KS-1:0][KS-1:0]  prod_next;
    prod_t [KS-1:0][KS-1:0]  prod_reg;
    row_sum_t [KS-1:0]       row_next;
    row_sum_t [KS-1:0]       row_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] rnd_sum;
    logic signed [SUM_W-1:0] shifted;
    conv3_pkg::pix_t         sat_value;
    conv3_pkg::out_item_t    res_reg;
    logic                    res_valid_reg;
    logic [2:0]              valid_pipe_reg;
    logic [2:0]              last_pipe_reg;

    // window row k meets kernel row 2-k, window column j meets element 2-j
    assign kern_rows = {coef_top, coef_mid, coef_bot};

    // stage 1: nine masked products
    always_comb
    begin
        logic signed [CW-1:0]               cf;
        logic signed [conv3_pkg::PIX_W-1:0] px;
        logic                               ok;
        cf = '0;
        px = '0;
        ok = 1'b0;
        prod_next = '0;
        for (int k = 0; k < KS; k++)
        begin
            for (int j = 0; j < KS; j++)
            begin
                cf = kern_rows[k][CW*(KS-1-j) +: CW];
                px = win[k][j];
                ok = ((k != 0) || ctrl.top_ok) && ((k != KS - 1) || ctrl.bot_ok)
                    && ((j != 0) || ctrl.left_ok) && ((j != KS - 1) || ctrl.right_ok);
                if (ok)
                begin
                    prod_next[k][j] = px * cf;
                end
            end
        end
    end

    // stage 2: row sums
    always_comb
    begin
        for (int k = 0; k < KS; k++)
        begin
            row_next[k] = ROW_SUM_W'(prod_reg[k][0]) + ROW_SUM_W'(prod_reg[k][1])
                + ROW_SUM_W'(prod_reg[k][2]);
        end
    end

    // stage 3: total
    assign sum_next = SUM_W'(row_reg[0]) + SUM_W'(row_reg[1]) + SUM_W'(row_reg[2]);

    // stage 4: round half up, drop fraction, saturate
    assign rnd_sum = sum_reg + SUM_W'(RND);
    assign shifted = rnd_sum >>> COEF_FRAC_BITS;

    always_comb
    begin
        if (shifted > SAT_MAX)
        begin
            sat_value = SAT_MAX[conv3_pkg::PIX_W-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            sat_value = SAT_MIN[conv3_pkg::PIX_W-1:0];
        end
        else
        begin
            sat_value = shifted[conv3_pkg::PIX_W-1:0];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg          <= prod_next;
        row_reg           <= row_next;
        sum_reg           <= sum_next;
        res_reg.out_value <= sat_value;
        res_reg.out_last  <= last_pipe_reg[2];
    end

    // control follows the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
            last_pipe_reg  <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_pipe_reg <= {valid_pipe_reg[1:0], ctrl.valid};
            last_pipe_reg  <= {last_pipe_reg[1:0], ctrl.valid && ctrl.last};
            res_valid_reg  <= valid_pipe_reg[2];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ hdl/conv3_ofifo.sv @@
module conv3_ofifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  conv3_pkg::out_item_t push_item,
    input  logic                 pop,
    output logic                 valid,
    output conv3_pkg::out_item_t item
);

    localparam int DEPTH = conv3_pkg::OFIFO_DEPTH;
    localparam int PTR_W = conv3_pkg::OFIFO_PTR_W;
    localparam int CNT_W = conv3_pkg::OCC_W;

    conv3_pkg::out_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 pop_xfer;

    assign pop_xfer = pop && (cnt_reg != '0);

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_reg + CNT_W'(push) - CNT_W'(pop_xfer);
        end
    end

    assign valid = (cnt_reg != '0);
    assign item  = slot_reg[rd_ptr_reg];

endmodule

@@ hdl/conv2d_3x3_zero_padded.sv @@
// a result is computed from the item that completes its neighbourhood, the item W + 1 stream
// positions later (W = image width), through the window stage, the mac stages and the result queue
// throughput: one item per cycle while the result queue has room; the 9-entry product stage and the line
// buffer ram, one read and one write a cycle with write-to-read bypass, set that figure
// reset: asynchronous, clears counters, window, queue and registers to defaults;
// the line buffer ram is not cleared, edge masking keeps stale entries out of results
module conv2d_3x3_zero_padded #(
    parameter int MAX_WIDTH      = 1024,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  pix_valid,
    output logic                                  pix_ready,
    input  conv3_pkg::in_item_t                   pix,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output conv3_pkg::out_item_t                  res,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [conv3_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [conv3_pkg::COEF_ROW_W-1:0]      cfg_data
);

    localparam int ADDR_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WID_W   = conv3_pkg::WIDTH_W;
    localparam int HGT_W   = conv3_pkg::HEIGHT_W;
    localparam int OROW_W  = conv3_pkg::OUT_ROW_W;
    localparam int OCC_W   = conv3_pkg::OCC_W;
    localparam int KS      = conv3_pkg::KERNEL_SIZE;
    localparam int WID_MAX = (1 << WID_W) - 1;
    localparam int WCAP    = (MAX_WIDTH < WID_MAX) ? MAX_WIDTH : WID_MAX;
    localparam logic [WID_W-1:0] WIDTH_CAP  = WID_W'(WCAP);
    localparam logic [HGT_W-1:0] HEIGHT_CAP = HGT_W'(conv3_pkg::MAX_HEIGHT);

    // configuration registers
    logic [conv3_pkg::COEF_ROW_W-1:0] coef_top_reg;
    logic [conv3_pkg::COEF_ROW_W-1:0] coef_mid_reg;
    logic [conv3_pkg::COEF_ROW_W-1:0] coef_bot_reg;
    logic [WID_W-1:0]                 width_reg;
    logic [HGT_W-1:0]                 height_reg;

    // stream position counters
    logic [ADDR_W-1:0] in_col_reg;
    logic [HGT_W-1:0]  in_row_reg;
    logic [ADDR_W-1:0] out_col_reg;
    logic [OROW_W-1:0] out_row_reg;
    logic [OCC_W-1:0]  occ_reg;

    // window stage
    logic                 s1_valid_reg;
    conv3_pkg::mac_ctrl_t s1_ctrl_reg;
    conv3_pkg::pix_t      s1_pix_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    conv3_pkg::win_t      win_reg;
    conv3_pkg::win_t      win_next;

    logic [WID_W-1:0]     w_eff;
    logic [WID_W-1:0]     w_m1;
    logic [HGT_W-1:0]     h_eff;
    logic [HGT_W-1:0]     h_m1;
    logic [ADDR_W-1:0]    col_end;
    logic [OROW_W-1:0]    row_end;
    logic                 cfg_xfer;
    logic                 geo_write;
    logic                 pix_xfer;
    logic                 res_xfer;
    logic                 emit;
    logic                 frame_last;
    conv3_pkg::pix_t      pix_in;
    conv3_pkg::mac_ctrl_t ctrl_next;
    conv3_pkg::lb_word_t  lb_rd;
    conv3_pkg::lb_word_t  lb_wr;
    logic                 mac_valid;
    conv3_pkg::out_item_t mac_res;

    // effective geometry, out-of-range values clamped
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (width_reg > WIDTH_CAP)
        begin
            w_eff = WIDTH_CAP;
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = HGT_W'(1);
        end
        else if (height_reg > HEIGHT_CAP)
        begin
            h_eff = HEIGHT_CAP;
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign w_m1    = w_eff - WID_W'(1);
    assign h_m1    = h_eff - HGT_W'(1);
    assign col_end = ADDR_W'(w_m1);
    assign row_end = h_m1[OROW_W-1:0];

    // handshakes
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign geo_write = cfg_xfer && ((cfg_index == conv3_pkg::CFG_IMAGE_WIDTH)
        || (cfg_index == conv3_pkg::CFG_IMAGE_HEIGHT));
    assign pix_ready = (occ_reg < OCC_W'(conv3_pkg::OFIFO_DEPTH));
    assign pix_xfer  = pix_valid && pix_ready;
    assign res_xfer  = res_valid && res_ready;

    // an output is due once W + 1 items of the frame have gone by
    assign emit       = (in_row_reg > HGT_W'(1)) || ((in_row_reg != '0) && (in_col_reg != '0));
    assign frame_last = (out_row_reg == row_end) && (out_col_reg == col_end);

    // drain items and items past the frame are zero pixels
    assign pix_in = ((pix.action == conv3_pkg::ACT_PIXEL) && (in_row_reg < h_eff))
        ? pix.pixel_value : '0;

    // edge masks for the output position
    always_comb
    begin
        ctrl_next.valid    = pix_xfer && emit;
        ctrl_next.last     = frame_last;
        ctrl_next.top_ok   = (out_row_reg != '0);
        ctrl_next.bot_ok   = (out_row_reg != row_end);
        ctrl_next.left_ok  = (out_col_reg != '0);
        ctrl_next.right_ok = (out_col_reg != col_end);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_top_reg <= conv3_pkg::COEF_TOP_RST;
            coef_mid_reg <= conv3_pkg::COEF_MID_RST;
            coef_bot_reg <= conv3_pkg::COEF_BOT_RST;
            width_reg    <= conv3_pkg::WIDTH_RST;
            height_reg   <= conv3_pkg::HEIGHT_RST;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg_index)
                conv3_pkg::CFG_COEF_TOP:     coef_top_reg <= cfg_data;
                conv3_pkg::CFG_COEF_MID:     coef_mid_reg <= cfg_data;
                conv3_pkg::CFG_COEF_BOT:     coef_bot_reg <= cfg_data;
                conv3_pkg::CFG_IMAGE_WIDTH:  width_reg    <= cfg_data[WID_W-1:0];
                conv3_pkg::CFG_IMAGE_HEIGHT: height_reg   <= cfg_data[HGT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input and output position counters, restart on geometry write or frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (geo_write)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (pix_xfer)
        begin
            if (emit && frame_last)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else
            begin
                if (in_col_reg == col_end)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + HGT_W'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + ADDR_W'(1);
                end
                if (emit)
                begin
                    if (out_col_reg == col_end)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + OROW_W'(1);
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + ADDR_W'(1);
                    end
                end
            end
        end
    end

    // results in flight or queued, bounds the queue fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_reg + OCC_W'(ctrl_next.valid) - OCC_W'(res_xfer);
        end
    end

    // hand the accepted item to the window stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_ctrl_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= pix_xfer;
            s1_ctrl_reg  <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_xfer)
        begin
            s1_pix_reg  <= pix_in;
            s1_addr_reg <= in_col_reg;
        end
    end

    // line buffers: read at transfer, written back in the next cycle
    assign lb_wr.newer = s1_pix_reg;
    assign lb_wr.older = lb_rd.newer;

    conv3_lbuf #(
        .DEPTH (MAX_WIDTH)
    ) u_lbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (pix_xfer),
        .rd_addr (in_col_reg),
        .rd_data (lb_rd),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (lb_wr)
    );

    // window shifts one column, new column from the line buffers and the pixel
    always_comb
    begin
        for (int k = 0; k < KS; k++)
        begin
            for (int j = 0; j < KS - 1; j++)
            begin
                win_next[k][j] = win_reg[k][j+1];
            end
        end
        win_next[0][KS-1] = lb_rd.older;
        win_next[1][KS-1] = lb_rd.newer;
        win_next[2][KS-1] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (geo_write)
        begin
            win_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_ctrl_reg.valid && s1_ctrl_reg.last)
            begin
                win_reg <= '0;
            end
            else
            begin
                win_reg <= win_next;
            end
        end
    end

    // products, sums, rounding and saturation
    conv3_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .win       (win_next),
        .ctrl      (s1_ctrl_reg),
        .coef_top  (coef_top_reg),
        .coef_mid  (coef_mid_reg),
        .coef_bot  (coef_bot_reg),
        .res_valid (mac_valid),
        .res       (mac_res)
    );

    // result queue decouples the output transfer from the pipeline
    conv3_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mac_valid),
        .push_item (mac_res),
        .pop       (res_ready),
        .valid     (res_valid),
        .item      (res)
    );

endmodule
